FILE: rtl/sli_pkg.sv
// Shared types and constants for the positional list block.
// Holds command and status codes, field widths and the sequencer state type.
// No dependencies.
package sli_pkg;

    // Field widths of the request and result items.
    localparam int CMD_W    = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 6;
    localparam int IN_W     = CMD_W + POS_W + VALUE_W;
    localparam int OUT_W    = STATUS_W + VALUE_W + LEN_W;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd2;

    // Sequencer states, one-hot.
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MOVE  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_PUT   = 6'b001000,
        S_FETCH = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

endpackage

FILE: rtl/sli_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Read data holds its value while no read is enabled.
// No dependencies.
module sli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/sequential_list_insert_delete.sv
// Positional list of signed 32-bit values with insert, delete and read.
// Channels: a request stream (s_tvalid/s_tready/s_tdata) carries cmd, position
// and value; a result stream (m_tvalid/m_tready/m_tdata) returns status,
// read_value and list_length, exactly one result per request.
// Entries live in one RAM with a registered read. Insert and delete
// move the later entries one place per cycle through a read/write pipeline on
// that RAM. The RAM's single write port sets the pace of the move.
// One request is worked on at a time; s_tready is high while the sequencer
// is idle, even when a finished result still waits in the output register.
// When the receiver stalls, the result is held and the next request is taken
// and processed up to its result, which then waits for the register to empty.
// Reset clears the length to zero and drops any pending result; the RAM is
// not cleared, since only entries below the length are ever read.
// Depends on sli_pkg and sli_ram.
module sequential_list_insert_delete #(
    parameter int DEPTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [1:0] cmd, [7:2] position, [39:8] value
    input  logic [sli_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [1:0] status, [33:2] read_value, [39:34] list_length
    output logic [sli_pkg::OUT_W-1:0] m_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > sli_pkg::POS_W) ? CW : sli_pkg::POS_W) + 1;

    sli_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                      count_reg, count_next;
    logic [sli_pkg::CMD_W-1:0]          cmd_reg, cmd_next;
    logic [sli_pkg::STATUS_W-1:0]       status_reg, status_next;
    logic signed [sli_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [AW-1:0]                      put_addr_reg, put_addr_next;
    logic [AW-1:0]                      ptr_reg, ptr_next;
    logic [AW-1:0]                      last_reg, last_next;
    logic [AW-1:0]                      wr_addr_reg, wr_addr_next;
    logic                               wr_pend_reg, wr_pend_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [sli_pkg::OUT_W-1:0]          out_data_reg, out_data_next;

    // Request fields.
    logic [sli_pkg::CMD_W-1:0]          in_cmd;
    logic [sli_pkg::POS_W-1:0]          in_pos;
    logic signed [sli_pkg::VALUE_W-1:0] in_value;
    logic [XW-1:0]                      pos_x;
    logic [XW-1:0]                      cnt_x;

    // RAM port signals.
    logic                               ram_wr_en;
    logic [AW-1:0]                      ram_wr_addr;
    logic [sli_pkg::VALUE_W-1:0]        ram_wr_data;
    logic                               ram_rd_en;
    logic [AW-1:0]                      ram_rd_addr;
    logic [sli_pkg::VALUE_W-1:0]        ram_rd_data;

    logic                               req_ok;
    logic signed [sli_pkg::VALUE_W-1:0] read_value;

    assign in_cmd   = s_tdata[sli_pkg::CMD_W-1:0];
    assign in_pos   = s_tdata[sli_pkg::CMD_W +: sli_pkg::POS_W];
    assign in_value = s_tdata[sli_pkg::CMD_W + sli_pkg::POS_W +: sli_pkg::VALUE_W];
    assign pos_x    = XW'(in_pos);
    assign cnt_x    = XW'(count_reg);

    assign s_tready = (state_reg == sli_pkg::S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    // Element store.
    sli_ram #(
        .WIDTH (sli_pkg::VALUE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // RAM access by state: moves read one entry and write the previous one.
    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_addr_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg;
        case (state_reg)
            sli_pkg::S_MOVE:
            begin
                ram_rd_en = 1'b1;
                ram_wr_en = wr_pend_reg;
            end
            sli_pkg::S_DRAIN:
            begin
                ram_wr_en = 1'b1;
            end
            sli_pkg::S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = put_addr_reg;
                ram_wr_data = value_reg;
            end
            sli_pkg::S_FETCH:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = put_addr_reg;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    // Result value: only a successful read returns an element.
    assign req_ok     = (status_reg == sli_pkg::STAT_OK);
    assign read_value = (cmd_reg == sli_pkg::CMD_READ && req_ok) ? ram_rd_data : '0;

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        cmd_next      = cmd_reg;
        status_next   = status_reg;
        value_next    = value_reg;
        put_addr_next = put_addr_reg;
        ptr_next      = ptr_reg;
        last_next     = last_reg;
        wr_addr_next  = wr_addr_reg;
        wr_pend_next  = wr_pend_reg;
        m_tvalid_next = m_tvalid_reg;
        out_data_next = out_data_reg;

        // The result register empties when the receiver takes it.
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            sli_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next      = in_cmd;
                    value_next    = in_value;
                    put_addr_next = AW'(pos_x - XW'(1));
                    wr_pend_next  = 1'b0;
                    status_next   = sli_pkg::STAT_BADPOS;
                    state_next    = sli_pkg::S_DONE;
                    case (in_cmd)
                        sli_pkg::CMD_INSERT:
                        begin
                            if (cnt_x >= XW'(DEPTH))
                            begin
                                status_next = sli_pkg::STAT_FULL;
                            end
                            else if (pos_x != '0 && pos_x <= cnt_x + XW'(1))
                            begin
                                status_next = sli_pkg::STAT_OK;
                                ptr_next    = AW'(cnt_x - XW'(1));
                                last_next   = AW'(pos_x - XW'(1));
                                if (pos_x <= cnt_x)
                                begin
                                    state_next = sli_pkg::S_MOVE;
                                end
                                else
                                begin
                                    state_next = sli_pkg::S_PUT;
                                end
                            end
                        end
                        sli_pkg::CMD_DELETE:
                        begin
                            if (pos_x != '0 && pos_x <= cnt_x)
                            begin
                                status_next = sli_pkg::STAT_OK;
                                ptr_next    = AW'(pos_x);
                                last_next   = AW'(cnt_x - XW'(1));
                                if (pos_x < cnt_x)
                                begin
                                    state_next = sli_pkg::S_MOVE;
                                end
                            end
                        end
                        sli_pkg::CMD_READ:
                        begin
                            if (pos_x != '0 && pos_x <= cnt_x)
                            begin
                                status_next = sli_pkg::STAT_OK;
                                state_next  = sli_pkg::S_FETCH;
                            end
                        end
                        default:
                        begin
                            status_next = sli_pkg::STAT_BADPOS;
                        end
                    endcase
                end
            end

            // One entry read per cycle; the entry read last cycle is written.
            sli_pkg::S_MOVE:
            begin
                wr_pend_next = 1'b1;
                if (cmd_reg == sli_pkg::CMD_INSERT)
                begin
                    wr_addr_next = ptr_reg + AW'(1);
                    ptr_next     = ptr_reg - AW'(1);
                end
                else
                begin
                    wr_addr_next = ptr_reg - AW'(1);
                    ptr_next     = ptr_reg + AW'(1);
                end
                if (ptr_reg == last_reg)
                begin
                    state_next = sli_pkg::S_DRAIN;
                end
            end

            // Write the final moved entry.
            sli_pkg::S_DRAIN:
            begin
                if (cmd_reg == sli_pkg::CMD_INSERT)
                begin
                    state_next = sli_pkg::S_PUT;
                end
                else
                begin
                    state_next = sli_pkg::S_DONE;
                end
            end

            // Write the inserted value into the opened slot.
            sli_pkg::S_PUT:
            begin
                state_next = sli_pkg::S_DONE;
            end

            // Read data arrives in the next cycle.
            sli_pkg::S_FETCH:
            begin
                state_next = sli_pkg::S_DONE;
            end

            // Load the result once the output register is free.
            sli_pkg::S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    if (req_ok && cmd_reg == sli_pkg::CMD_INSERT)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    else if (req_ok && cmd_reg == sli_pkg::CMD_DELETE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                    m_tvalid_next = 1'b1;
                    out_data_next = {sli_pkg::LEN_W'(count_next), read_value, status_reg};
                    state_next    = sli_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = sli_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sli_pkg::S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
            wr_pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
            wr_pend_reg  <= wr_pend_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        status_reg   <= status_next;
        value_reg    <= value_next;
        put_addr_reg <= put_addr_next;
        ptr_reg      <= ptr_next;
        last_reg     <= last_next;
        wr_addr_reg  <= wr_addr_next;
        out_data_reg <= out_data_next;
    end

endmodule

FILE: tb/sv/sequential_list_insert_delete_tb.sv
// Self-checking testbench for the positional list block (insert, delete, read).
// Drives request streams from a queue, predicts each result in a local list model
// and checks the result stream field by field. Depends on sli_pkg and the block's RTL.
module sequential_list_insert_delete_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 32;
    localparam int IDLE_PCT = 28;
    localparam int N_ITEMS  = 1050;
    localparam int HOLD_LEN = 400;

    // The one command code that the package leaves unnamed.
    localparam logic [sli_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    // Phases of the random part.
    typedef enum int { PH_FILL, PH_DRAIN, PH_MIXED } phase_t;

    typedef struct packed {
        logic [sli_pkg::STATUS_W-1:0]       status;
        logic signed [sli_pkg::VALUE_W-1:0] read_value;
        logic [sli_pkg::LEN_W-1:0]          list_length;
    } list_result_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // [1:0] cmd, [7:2] position, [39:8] value
    logic [sli_pkg::IN_W-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // [1:0] status, [33:2] read_value, [39:34] list_length
    logic [sli_pkg::OUT_W-1:0] m_tdata;

    logic [sli_pkg::IN_W-1:0]  pending_requests[$];
    list_result_t              expected_results[$];

    // Local copy of the list, updated as each request is accepted.
    logic signed [sli_pkg::VALUE_W-1:0] shadow_list[DEPTH];
    int                                 shadow_len = 0;

    // Length seen by the stimulus builder, used to aim positions.
    int gen_len = 0;

    int total_items = 0;
    int sent_cnt = 0;
    int results_seen = 0;
    int errors = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    sequential_list_insert_delete #(
        .DEPTH(DEPTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata)
    );

    // 50 MHz clock.
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Applies one command to the local list and returns the result it should give.
    function automatic list_result_t list_apply(logic [sli_pkg::CMD_W-1:0] op,
                                                logic [sli_pkg::POS_W-1:0] pos,
                                                logic signed [sli_pkg::VALUE_W-1:0] val);
        list_result_t r;
        int p;
        p = int'(pos);
        r.status = sli_pkg::STAT_BADPOS;
        r.read_value = '0;
        case (op)
            sli_pkg::CMD_INSERT:
            begin
                // A full list is refused before the position is looked at.
                if (shadow_len >= DEPTH)
                    r.status = sli_pkg::STAT_FULL;
                else if (p >= 1 && p <= shadow_len + 1)
                begin
                    for (int j = shadow_len; j > p - 1; j--)
                        shadow_list[j] = shadow_list[j - 1];
                    shadow_list[p - 1] = val;
                    shadow_len++;
                    r.status = sli_pkg::STAT_OK;
                end
            end
            sli_pkg::CMD_DELETE:
            begin
                if (p >= 1 && p <= shadow_len)
                begin
                    for (int j = p; j < shadow_len; j++)
                        shadow_list[j - 1] = shadow_list[j];
                    shadow_len--;
                    r.status = sli_pkg::STAT_OK;
                end
            end
            sli_pkg::CMD_READ:
            begin
                if (p >= 1 && p <= shadow_len)
                begin
                    r.read_value = shadow_list[p - 1];
                    r.status = sli_pkg::STAT_OK;
                end
            end
            default:
                r.status = sli_pkg::STAT_BADPOS;
        endcase
        r.list_length = shadow_len[sli_pkg::LEN_W-1:0];
        return r;
    endfunction

    // Queues one request and keeps track of the length it leaves behind.
    task automatic add_request(logic [sli_pkg::CMD_W-1:0] op, int pos,
                               logic [sli_pkg::VALUE_W-1:0] val);
        pending_requests.push_back({val, pos[sli_pkg::POS_W-1:0], op});
        if (op == sli_pkg::CMD_INSERT && gen_len < DEPTH && pos >= 1 && pos <= gen_len + 1)
            gen_len++;
        else if (op == sli_pkg::CMD_DELETE && pos >= 1 && pos <= gen_len)
            gen_len--;
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    // Request driver: computes the expected result as each request is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(list_apply(s_tdata[1:0], s_tdata[7:2],
                                                      s_tdata[39:8]));
                sent_cnt++;
            end
            if (!s_tvalid || s_tready)
            begin
                // No gaps while requests 500 to 649 go out.
                if (pending_requests.size() != 0 &&
                    ((sent_cnt >= 500 && sent_cnt < 650) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_requests.pop_front();
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // One long receiver hold-off, so that the block fills and stalls its input.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= 150)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Result monitor and ready driver.
    always @(posedge clk)
    begin
        list_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata, 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[33:2] !== want.read_value)
                        report_mismatch("read_value", m_tdata[33:2], want.read_value);
                    if (m_tdata[39:34] !== want.list_length)
                        report_mismatch("list_length", m_tdata[39:34], want.list_length);
                end
            end
            // Ready without gaps while results 500 to 649 come back.
            m_tready <= (hold_left == 0) &&
                        ((results_seen >= 500 && results_seen < 650) ||
                         $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        phase_t ph;
        int     block_left;
        int     r;
        int     pos;
        logic [sli_pkg::CMD_W-1:0] op;

        // Refused requests on an empty list and the unused command code.
        add_request(sli_pkg::CMD_READ, 1, 32'h1234_5678);
        add_request(sli_pkg::CMD_DELETE, 0, 32'h0);
        add_request(sli_pkg::CMD_INSERT, 0, 32'h5555_5555);
        add_request(sli_pkg::CMD_INSERT, 2, 32'hAAAA_AAAA);
        add_request(CMD_UNUSED, 63, 32'hFFFF_FFFF);
        // Inserts at the front, at the end and in the middle, with extreme values.
        add_request(sli_pkg::CMD_INSERT, 1, 32'h7FFF_FFFF);
        add_request(sli_pkg::CMD_INSERT, 1, 32'h8000_0000);
        add_request(sli_pkg::CMD_INSERT, 3, 32'hFFFF_FFFF);
        add_request(sli_pkg::CMD_INSERT, 2, 32'h0000_0000);
        add_request(sli_pkg::CMD_INSERT, 6, 32'h1);
        add_request(sli_pkg::CMD_READ, 1, 32'h0);
        add_request(sli_pkg::CMD_READ, 2, 32'h0);
        add_request(sli_pkg::CMD_READ, 3, 32'h0);
        add_request(sli_pkg::CMD_READ, 4, 32'h0);
        add_request(sli_pkg::CMD_READ, 5, 32'h0);
        add_request(sli_pkg::CMD_READ, 63, 32'h0);
        add_request(sli_pkg::CMD_READ, 0, 32'h0);
        // Deletes of the last and the first entry, then out of range.
        add_request(sli_pkg::CMD_DELETE, 4, 32'h0);
        add_request(sli_pkg::CMD_DELETE, 1, 32'h0);
        add_request(sli_pkg::CMD_DELETE, 3, 32'h0);
        add_request(sli_pkg::CMD_DELETE, 32, 32'h0);
        add_request(CMD_UNUSED, 1, 32'h0);
        add_request(sli_pkg::CMD_READ, 2, 32'h0);

        // Random blocks of requests, each leaning toward filling, draining or neither.
        ph = PH_FILL;
        block_left = 80;
        while (pending_requests.size() < N_ITEMS)
        begin
            if (block_left == 0)
            begin
                ph = phase_t'($urandom_range(0, 2));
                block_left = $urandom_range(40, 80);
            end
            block_left--;
            r = $urandom_range(0, 99);
            case (ph)
                PH_FILL:  op = (r < 65) ? sli_pkg::CMD_INSERT :
                               (r < 75) ? sli_pkg::CMD_DELETE :
                               (r < 97) ? sli_pkg::CMD_READ : CMD_UNUSED;
                PH_DRAIN: op = (r < 15) ? sli_pkg::CMD_INSERT :
                               (r < 65) ? sli_pkg::CMD_DELETE :
                               (r < 97) ? sli_pkg::CMD_READ : CMD_UNUSED;
                default:  op = (r < 35) ? sli_pkg::CMD_INSERT :
                               (r < 65) ? sli_pkg::CMD_DELETE :
                               (r < 97) ? sli_pkg::CMD_READ : CMD_UNUSED;
            endcase
            // Most positions are in range; the rest cover the whole field.
            if ($urandom_range(0, 99) < 15)
                pos = $urandom_range(0, 63);
            else if (op == sli_pkg::CMD_INSERT)
                pos = $urandom_range(1, gen_len + 1);
            else if (gen_len > 0)
                pos = $urandom_range(1, gen_len);
            else
                pos = 1;
            add_request(op, pos, $urandom());
        end
        total_items = pending_requests.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt < total_items)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        // Let any stray result show up before the verdict.
        repeat (2 * DEPTH + 16) @(posedge clk);
        if (errors == 0)
            $display("sequential_list_insert_delete_tb: clean");
        else
            $display("sequential_list_insert_delete_tb: errors");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #20_000_000;
        $display("sequential_list_insert_delete_tb: errors");
        $finish;
    end

endmodule
